// ===== rtl/linear_probe_hash_map_macros.svh =====
// ----------------------------------------------------------------------------
// linear_probe_hash_map_macros.svh
// Assertion macros used by the hash map checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_MAP_MACROS_SVH
`define LINEAR_PROBE_HASH_MAP_MACROS_SVH

// Clocked, reset-gated assertion; expects clk_i and rst_ni in scope.
`define LPHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Next-cycle implication.
`define LPHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  `LPHM_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/lphm_pkg.sv =====
// ----------------------------------------------------------------------------
// lphm_pkg
// Types and constants of the linear probing hash map.
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned FLAGS_W  = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 10;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_ZERO_KEY = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_DEC, ST_CLR,
    ST_LDIV, ST_LRD, ST_LCMP,
    ST_IDIV, ST_IRD, ST_ICMP,
    ST_GCLR, ST_GRD, ST_GCHK, ST_GDIV, ST_GPRD, ST_GPCMP, ST_GFIN,
    ST_RESP
  } state_e;

  typedef enum logic [2:0] {
    RES_NONE, RES_CLR, RES_HIT, RES_FULL, RES_ZERO_KEY
  } res_e;

  typedef enum logic [1:0] {
    WR_ZERO, WR_INPUT, WR_REHASH
  } wr_src_e;

  typedef struct packed {
    logic    capture;
    logic    dec_clear;
    logic    grow_commit;
    logic    cnt_inc;
    logic    div_start;
    logic    use_new;
    logic    probe_init;
    logic    probe_next;
    logic    sweep_next;
    logic    slot_clr;
    logic    t_clr;
    logic    t_next;
    logic    rd_en;
    logic    rd_other;
    logic    rd_by_t;
    logic    wr_en;
    logic    wr_other;
    wr_src_e wr_src;
    logic    latch_r;
    res_e    res_op;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    key_zero;
    logic    grow_need;
    logic    full;
    logic    div_busy;
    logic    key_match;
    logic    slot_empty;
    logic    probe_last_cur;
    logic    probe_last_new;
    logic    sweep_last_start;
    logic    sweep_last_new;
    logic    t_last;
    logic    out_free;
  } sts_t;

endpackage

// ===== rtl/lphm_ram.sv =====
// ----------------------------------------------------------------------------
// lphm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lphm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/lphm_div.sv =====
// ----------------------------------------------------------------------------
// lphm_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lphm_div #(
  parameter int unsigned DIVIDEND_W = 32,
  parameter int unsigned DIVISOR_W  = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [DIVISOR_W-1:0]  rem_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W:0]    rem_q;
  logic [DIVISOR_W-1:0]  div_q;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    rem_d;

  always_comb begin
    shifted = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
    if (shifted >= {1'b0, div_q}) begin
      rem_d = shifted - {1'b0, div_q};
    end else begin
      rem_d = shifted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIVIDEND_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q[DIVISOR_W-1:0];

endmodule

// ===== rtl/lphm_dp.sv =====
// ----------------------------------------------------------------------------
// lphm_dp
// Hash map datapath: banked key and payload RAMs, counters, result registers.
// ----------------------------------------------------------------------------
module lphm_dp #(
  parameter int unsigned TABLE_DEPTH      = 1024,
  parameter int unsigned INITIAL_CAPACITY = 11,
  parameter int unsigned KEY_WIDTH        = 32,
  parameter int unsigned VALUE_WIDTH      = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lphm_pkg::cmd_t                      cmd_i,
  output lphm_pkg::sts_t                      sts_o,
  input  logic [lphm_pkg::OPCODE_W-1:0]       in_op_i,
  input  logic [KEY_WIDTH-1:0]                in_key_i,
  input  logic [VALUE_WIDTH-1:0]              in_value_i,
  input  logic [lphm_pkg::FLAGS_W-1:0]        in_flags_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_hit_o,
  output logic [VALUE_WIDTH-1:0]              out_value_o,
  output logic [lphm_pkg::FLAGS_W-1:0]        out_flags_o,
  output logic [lphm_pkg::STATUS_W-1:0]       out_status_o,
  output logic [lphm_pkg::COUNT_W-1:0]        out_count_o
);

  import lphm_pkg::*;

  localparam int unsigned SW        = $clog2(TABLE_DEPTH);
  localparam int unsigned CW        = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RAM_DEPTH = 2 * TABLE_DEPTH;
  localparam int unsigned AW        = $clog2(RAM_DEPTH);
  localparam int unsigned PW        = VALUE_WIDTH + FLAGS_W;
  localparam int unsigned START_CAP =
      (INITIAL_CAPACITY > TABLE_DEPTH) ? TABLE_DEPTH : INITIAL_CAPACITY;

  function automatic logic [AW-1:0] slot_addr(input logic b, input logic [SW-1:0] s);
    slot_addr = AW'(s) + (b ? AW'(TABLE_DEPTH) : AW'(0));
  endfunction

  opcode_e              op_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [FLAGS_W-1:0]   flg_q;
  logic [CW-1:0]        cap_q;
  logic [CW-1:0]        cnt_q;
  logic                 bank_q;
  logic [SW-1:0]        slot_q;
  logic [SW-1:0]        n_q;
  logic [SW-1:0]        t_q;
  logic [KEY_WIDTH-1:0] rkey_q;
  logic [PW-1:0]        rpay_q;
  logic                 res_hit_q;
  logic [VALUE_WIDTH-1:0] res_val_q;
  logic [FLAGS_W-1:0]   res_flg_q;
  logic [STATUS_W-1:0]  res_stat_q;
  logic                 out_valid_q;
  logic                 out_hit_q;
  logic [VALUE_WIDTH-1:0] out_val_q;
  logic [FLAGS_W-1:0]   out_flg_q;
  logic [STATUS_W-1:0]  out_stat_q;
  logic [COUNT_W-1:0]   out_cnt_q;

  logic [CW:0]          new_cap_w;
  logic [CW-1:0]        new_cap;
  logic [CW-1:0]        lim;
  logic [CW-1:0]        slot_inc;
  logic [SW-1:0]        slot_wrap;
  logic                 div_busy;
  logic [CW-1:0]        div_rem;
  logic [KEY_WIDTH-1:0] k_rdata;
  logic [PW-1:0]        p_rdata;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_key;
  logic [PW-1:0]        wr_pay;

  assign new_cap_w = {cap_q, 1'b1};
  assign new_cap   = new_cap_w[CW-1:0];
  assign lim       = cmd_i.use_new ? new_cap : cap_q;
  assign slot_inc  = CW'(slot_q) + CW'(1);
  assign slot_wrap = (slot_inc == lim) ? '0 : slot_inc[SW-1:0];

  assign rd_addr = slot_addr(bank_q ^ cmd_i.rd_other, cmd_i.rd_by_t ? t_q : slot_q);
  assign wr_addr = slot_addr(bank_q ^ cmd_i.wr_other, slot_q);

  always_comb begin
    case (cmd_i.wr_src)
      WR_INPUT: begin
        wr_key = key_q;
        wr_pay = {flg_q, val_q};
      end
      WR_REHASH: begin
        wr_key = rkey_q;
        wr_pay = rpay_q;
      end
      default: begin
        wr_key = '0;
        wr_pay = '0;
      end
    endcase
  end

  lphm_ram #(.WIDTH(KEY_WIDTH), .DEPTH(RAM_DEPTH)) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_key),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (k_rdata)
  );

  lphm_ram #(.WIDTH(PW), .DEPTH(RAM_DEPTH)) u_pay_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_pay),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (p_rdata)
  );

  // rehash takes its key straight from the read port; latch happens same edge
  lphm_div #(.DIVIDEND_W(KEY_WIDTH), .DIVISOR_W(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.use_new ? k_rdata : key_q),
    .divisor_i  (cmd_i.use_new ? new_cap : cap_q),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  always_comb begin
    sts_o.op               = op_q;
    sts_o.key_zero         = (key_q == '0);
    sts_o.grow_need        = ((cap_q - cnt_q) <= (cap_q >> 2)) &&
                             (new_cap_w <= (CW+1)'(TABLE_DEPTH));
    sts_o.full             = (cnt_q >= cap_q);
    sts_o.div_busy         = div_busy;
    sts_o.key_match        = (k_rdata == key_q);
    sts_o.slot_empty       = (k_rdata == '0);
    sts_o.probe_last_cur   = ((CW'(n_q) + CW'(1)) == cap_q);
    sts_o.probe_last_new   = ((CW'(n_q) + CW'(1)) == new_cap);
    sts_o.sweep_last_start = (slot_inc == CW'(START_CAP));
    sts_o.sweep_last_new   = (slot_inc == new_cap);
    sts_o.t_last           = ((CW'(t_q) + CW'(1)) == cap_q);
    sts_o.out_free         = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CW'(START_CAP);
      cnt_q       <= '0;
      bank_q      <= 1'b0;
      slot_q      <= '0;
      n_q         <= '0;
      t_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.dec_clear) begin
        cap_q  <= CW'(START_CAP);
        cnt_q  <= '0;
        bank_q <= 1'b0;
      end else if (cmd_i.grow_commit) begin
        cap_q  <= new_cap;
        bank_q <= ~bank_q;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.slot_clr) begin
        slot_q <= '0;
      end else if (cmd_i.probe_init) begin
        slot_q <= div_rem[SW-1:0];
      end else if (cmd_i.probe_next) begin
        slot_q <= slot_wrap;
      end else if (cmd_i.sweep_next) begin
        slot_q <= slot_inc[SW-1:0];
      end
      if (cmd_i.probe_init) begin
        n_q <= '0;
      end else if (cmd_i.probe_next) begin
        n_q <= n_q + SW'(1);
      end
      if (cmd_i.t_clr) begin
        t_q <= '0;
      end else if (cmd_i.t_next) begin
        t_q <= t_q + SW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_e'(in_op_i);
      key_q <= in_key_i;
      val_q <= in_value_i;
      flg_q <= in_flags_i;
    end
    if (cmd_i.latch_r) begin
      rkey_q <= k_rdata;
      rpay_q <= p_rdata;
    end
    case (cmd_i.res_op)
      RES_CLR: begin
        res_hit_q  <= 1'b0;
        res_val_q  <= '0;
        res_flg_q  <= '0;
        res_stat_q <= STAT_OK;
      end
      RES_HIT: begin
        res_hit_q  <= 1'b1;
        res_val_q  <= p_rdata[VALUE_WIDTH-1:0];
        res_flg_q  <= p_rdata[PW-1:VALUE_WIDTH];
        res_stat_q <= STAT_OK;
      end
      RES_FULL: begin
        res_hit_q  <= 1'b0;
        res_val_q  <= '0;
        res_flg_q  <= '0;
        res_stat_q <= STAT_FULL;
      end
      RES_ZERO_KEY: begin
        res_hit_q  <= 1'b0;
        res_val_q  <= '0;
        res_flg_q  <= '0;
        res_stat_q <= STAT_ZERO_KEY;
      end
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      out_hit_q  <= res_hit_q;
      out_val_q  <= res_val_q;
      out_flg_q  <= res_flg_q;
      out_stat_q <= res_stat_q;
      out_cnt_q  <= COUNT_W'(cnt_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_hit_o    = out_hit_q;
  assign out_value_o  = out_val_q;
  assign out_flags_o  = out_flg_q;
  assign out_status_o = out_stat_q;
  assign out_count_o  = out_cnt_q;

endmodule

// ===== rtl/lphm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lphm_ctrl
// Hash map sequencer: decode, probe, grow/rehash and clearing sweeps.
// ----------------------------------------------------------------------------
module lphm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lphm_pkg::sts_t sts_i,
  output lphm_pkg::cmd_t cmd_o
);

  import lphm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: if (sts_i.sweep_last_start) state_d = ST_IDLE;
      ST_IDLE: if (in_valid_i) state_d = ST_DEC;
      ST_DEC: begin
        case (sts_i.op)
          OP_LOOKUP: state_d = sts_i.key_zero ? ST_RESP : ST_LDIV;
          OP_INSERT: begin
            if (sts_i.key_zero)       state_d = ST_RESP;
            else if (sts_i.grow_need) state_d = ST_GCLR;
            else if (sts_i.full)      state_d = ST_RESP;
            else                      state_d = ST_IDIV;
          end
          OP_CLEAR: state_d = ST_CLR;
          default:  state_d = ST_RESP;
        endcase
      end
      ST_CLR:  if (sts_i.sweep_last_start) state_d = ST_RESP;
      ST_LDIV: if (!sts_i.div_busy) state_d = ST_LRD;
      ST_LRD:  state_d = ST_LCMP;
      ST_LCMP: begin
        if (sts_i.key_match || sts_i.slot_empty || sts_i.probe_last_cur) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_LRD;
        end
      end
      ST_IDIV: if (!sts_i.div_busy) state_d = ST_IRD;
      ST_IRD:  state_d = ST_ICMP;
      ST_ICMP: begin
        if (sts_i.slot_empty || sts_i.probe_last_cur) state_d = ST_RESP;
        else                                          state_d = ST_IRD;
      end
      ST_GCLR: if (sts_i.sweep_last_new) state_d = ST_GRD;
      ST_GRD:  state_d = ST_GCHK;
      ST_GCHK: begin
        if (!sts_i.slot_empty)  state_d = ST_GDIV;
        else if (sts_i.t_last)  state_d = ST_GFIN;
        else                    state_d = ST_GRD;
      end
      ST_GDIV: if (!sts_i.div_busy) state_d = ST_GPRD;
      ST_GPRD: state_d = ST_GPCMP;
      ST_GPCMP: begin
        if (sts_i.slot_empty || sts_i.probe_last_new) begin
          state_d = sts_i.t_last ? ST_GFIN : ST_GRD;
        end else begin
          state_d = ST_GPRD;
        end
      end
      ST_GFIN: state_d = ST_DEC;
      ST_RESP: if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.wr_src = WR_ZERO;
    cmd_o.res_op = RES_NONE;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_INIT, ST_CLR: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.sweep_next = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DEC: begin
        cmd_o.res_op = RES_CLR;
        case (sts_i.op)
          OP_LOOKUP: cmd_o.div_start = !sts_i.key_zero;
          OP_INSERT: begin
            if (sts_i.key_zero)       cmd_o.res_op    = RES_ZERO_KEY;
            else if (sts_i.grow_need) cmd_o.slot_clr  = 1'b1;
            else if (sts_i.full)      cmd_o.res_op    = RES_FULL;
            else                      cmd_o.div_start = 1'b1;
          end
          OP_CLEAR: begin
            cmd_o.dec_clear = 1'b1;
            cmd_o.slot_clr  = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_LDIV, ST_IDIV: cmd_o.probe_init = !sts_i.div_busy;
      ST_LRD, ST_IRD:   cmd_o.rd_en = 1'b1;
      ST_LCMP: begin
        if (sts_i.key_match) begin
          cmd_o.res_op = RES_HIT;
        end else if (!sts_i.slot_empty && !sts_i.probe_last_cur) begin
          cmd_o.probe_next = 1'b1;
        end
      end
      ST_ICMP: begin
        if (sts_i.slot_empty) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_src  = WR_INPUT;
          cmd_o.cnt_inc = 1'b1;
        end else if (!sts_i.probe_last_cur) begin
          cmd_o.probe_next = 1'b1;
        end
      end
      ST_GCLR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_other = 1'b1;
        if (sts_i.sweep_last_new) cmd_o.t_clr      = 1'b1;
        else                      cmd_o.sweep_next = 1'b1;
      end
      ST_GRD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_by_t = 1'b1;
      end
      ST_GCHK: begin
        cmd_o.latch_r = 1'b1;
        cmd_o.use_new = 1'b1;
        if (sts_i.slot_empty) cmd_o.t_next    = 1'b1;
        else                  cmd_o.div_start = 1'b1;
      end
      ST_GDIV: begin
        cmd_o.use_new    = 1'b1;
        cmd_o.probe_init = !sts_i.div_busy;
      end
      ST_GPRD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_other = 1'b1;
      end
      ST_GPCMP: begin
        cmd_o.use_new = 1'b1;
        if (sts_i.slot_empty) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_other = 1'b1;
          cmd_o.wr_src   = WR_REHASH;
          cmd_o.t_next   = 1'b1;
        end else if (sts_i.probe_last_new) begin
          cmd_o.t_next = 1'b1;
        end else begin
          cmd_o.probe_next = 1'b1;
        end
      end
      ST_GFIN: cmd_o.grow_commit = 1'b1;
      ST_RESP: cmd_o.out_load = sts_i.out_free;
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/linear_probe_hash_map.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// Open-addressing key/value map with linear probing and growth by rehash.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one command beat: tuser = opcode (lookup, insert,
//   clear), tdata = key, value, flags. Master stream returns one result beat
//   per command: tuser = hit, tdata = found value, flags, status, count.
//   One command is in flight at a time; the next is taken as soon as the
//   previous result sits in the output register, even if it is not yet taken.
// Sequence per command:
//   lookup/insert: modulo unit, then one RAM read and compare per probed
//   slot; zero key, full table, nop: decode, then the response.
//   grow (inside an insert): the new bank is cleared, then each old slot
//   is read and each live entry is rehashed by the modulo unit and probed.
//   clear: sweep of bank 0.
// Reset: a sweep zeroes the bank 0 slots of the initial capacity; tready is
//   low meanwhile. Growth always clears the slots it will use.
// Stall: a held result blocks the next result only; the block waits in its
//   response step until the master side frees the output register.
// ----------------------------------------------------------------------------
module linear_probe_hash_map #(
  parameter int unsigned TABLE_DEPTH      = 1024,
  parameter int unsigned INITIAL_CAPACITY = 11,
  parameter int unsigned KEY_WIDTH        = 32,
  parameter int unsigned VALUE_WIDTH      = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // key, value, entry_flags[7:0], zero pad to bytes
  input  logic [((KEY_WIDTH+VALUE_WIDTH+lphm_pkg::FLAGS_W+7)/8)*8-1:0] s_axis_tdata_i,
  // opcode[1:0]
  input  logic [lphm_pkg::OPCODE_W-1:0] s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // found_value, found_flags[7:0], status[1:0], entry_count[9:0], zero pad
  output logic [((VALUE_WIDTH+lphm_pkg::FLAGS_W+lphm_pkg::STATUS_W+
                  lphm_pkg::COUNT_W+7)/8)*8-1:0] m_axis_tdata_o,
  // hit
  output logic                     m_axis_tuser_o
);

  import lphm_pkg::*;

  localparam int unsigned ODW = ((VALUE_WIDTH+FLAGS_W+STATUS_W+COUNT_W+7)/8)*8;

  cmd_t                   cmd;
  sts_t                   sts;
  logic [VALUE_WIDTH-1:0] out_value;
  logic [FLAGS_W-1:0]     out_flags;
  logic [STATUS_W-1:0]    out_status;
  logic [COUNT_W-1:0]     out_count;

  lphm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lphm_dp #(
    .TABLE_DEPTH      (TABLE_DEPTH),
    .INITIAL_CAPACITY (INITIAL_CAPACITY),
    .KEY_WIDTH        (KEY_WIDTH),
    .VALUE_WIDTH      (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (s_axis_tuser_i),
    .in_key_i     (s_axis_tdata_i[KEY_WIDTH-1:0]),
    .in_value_i   (s_axis_tdata_i[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH]),
    .in_flags_i   (s_axis_tdata_i[KEY_WIDTH+VALUE_WIDTH+FLAGS_W-1:KEY_WIDTH+VALUE_WIDTH]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_hit_o    (m_axis_tuser_o),
    .out_value_o  (out_value),
    .out_flags_o  (out_flags),
    .out_status_o (out_status),
    .out_count_o  (out_count)
  );

  // result beat packed low to high, pad bits zero
  assign m_axis_tdata_o = ODW'({out_count, out_status, out_flags, out_value});

endmodule

// ===== rtl/lphm_checker.sv =====
// ----------------------------------------------------------------------------
// lphm_checker
// Port-level checks of the hash map result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_map_macros.svh"

module lphm_checker #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid_i,
  input logic s_axis_tready_o,
  input logic m_axis_tvalid_o,
  input logic m_axis_tready_i,
  input logic [((VALUE_WIDTH+lphm_pkg::FLAGS_W+lphm_pkg::STATUS_W+
                 lphm_pkg::COUNT_W+7)/8)*8-1:0] m_axis_tdata_o,
  input logic m_axis_tuser_o
);

  import lphm_pkg::*;

  localparam int unsigned ST_LO = VALUE_WIDTH + FLAGS_W;

  logic [STATUS_W-1:0] status;
  logic                miss_clean;

  assign status     = m_axis_tdata_o[ST_LO+STATUS_W-1:ST_LO];
  assign miss_clean = (m_axis_tdata_o[ST_LO-1:0] == '0);

  `LPHM_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "result dropped while stalled")
  `LPHM_ASSERT_NEXT(a_one_cmd, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "second command taken while busy")
  `LPHM_ASSERT(a_hit_ok, m_axis_tvalid_o && m_axis_tuser_o |-> status == STAT_OK, "hit with error status")
  `LPHM_ASSERT(a_miss_zero, m_axis_tvalid_o && !m_axis_tuser_o |-> miss_clean, "miss with payload")
  `LPHM_ASSERT(a_status_code, m_axis_tvalid_o |-> status <= STAT_ZERO_KEY, "undefined status code")

endmodule

bind linear_probe_hash_map lphm_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_lphm_checker (.*);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stream test of the linear probing hash map: a queue of command beats is
// driven at random pace, each result beat is checked against an in-bench map
// model with growth, rehash, full-table and zero-key handling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import lphm_pkg::*;

  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned INIT_CAP = 11;
  localparam int unsigned CYC_LIMIT = 20000000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value;
    logic [7:0]  flags;
  } cmd_beat_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
    logic [7:0]  flags;
    logic [1:0]  status;
    logic [9:0]  count;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [71:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [55:0] m_data;
  logic        m_user;

  linear_probe_hash_map u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Map model: two banks of keys and payloads.
  logic [31:0] mdl_key [2*DEPTH];
  logic [31:0] mdl_val [2*DEPTH];
  logic [7:0]  mdl_flg [2*DEPTH];
  int unsigned mdl_cap, mdl_cnt, mdl_bank;

  cmd_beat_t   pending_cmds[$];
  result_t     expected_results[$];
  int unsigned mismatches = 0;
  int unsigned cyc = 0;
  bit          stim_done = 0;
  bit          no_idle = 0;       // burst window without gaps
  int unsigned hold_off = 0;      // long receiver stall, in cycles

  function automatic void map_clear();
    for (int i = 0; i < 2*DEPTH; i++) mdl_key[i] = '0;
    mdl_cap = INIT_CAP; mdl_cnt = 0; mdl_bank = 0;
  endfunction

  function automatic void map_grow();
    int unsigned ncap, src, dst, s;
    logic [31:0] k;
    ncap = mdl_cap*2 + 1;
    src = mdl_bank*DEPTH;
    dst = (mdl_bank^1)*DEPTH;
    if (ncap > DEPTH) return;
    for (int i = 0; i < DEPTH; i++) mdl_key[dst+i] = '0;
    for (int t = 0; t < mdl_cap; t++) begin
      k = mdl_key[src+t];
      if (k == 0) continue;
      s = k % ncap;
      for (int n = 0; n < ncap; n++) begin
        if (mdl_key[dst+s] == 0) begin
          mdl_key[dst+s] = k;
          mdl_val[dst+s] = mdl_val[src+t];
          mdl_flg[dst+s] = mdl_flg[src+t];
          break;
        end
        s = (s+1 == ncap) ? 0 : s+1;
      end
    end
    mdl_cap = ncap;
    mdl_bank ^= 1;
  endfunction

  function automatic result_t map_apply(cmd_beat_t c);
    result_t r;
    int unsigned base, s;
    r = '0;
    base = mdl_bank*DEPTH;
    case (c.op)
      OP_LOOKUP: begin
        if (c.key != 0) begin
          s = c.key % mdl_cap;
          for (int n = 0; n < mdl_cap; n++) begin
            if (mdl_key[base+s] == c.key) begin
              r.hit = 1'b1; r.value = mdl_val[base+s]; r.flags = mdl_flg[base+s];
              break;
            end
            if (mdl_key[base+s] == 0) break;
            s = (s+1 == mdl_cap) ? 0 : s+1;
          end
        end
      end
      OP_INSERT: begin
        if (c.key == 0) r.status = STAT_ZERO_KEY;
        else begin
          if (mdl_cap - mdl_cnt <= mdl_cap/4) begin
            map_grow();
            base = mdl_bank*DEPTH;
          end
          if (mdl_cnt >= mdl_cap) r.status = STAT_FULL;
          else begin
            s = c.key % mdl_cap;
            for (int n = 0; n < mdl_cap; n++) begin
              if (mdl_key[base+s] == 0) begin
                mdl_key[base+s] = c.key;
                mdl_val[base+s] = c.value;
                mdl_flg[base+s] = c.flags;
                mdl_cnt++;
                break;
              end
              s = (s+1 == mdl_cap) ? 0 : s+1;
            end
          end
        end
      end
      OP_CLEAR: map_clear();
      default: ;
    endcase
    r.count = mdl_cnt[9:0];
    return r;
  endfunction

  function automatic cmd_beat_t mk_cmd(logic [1:0] op, logic [31:0] k,
                                       logic [31:0] v, logic [7:0] f);
    cmd_beat_t c;
    c.op = op; c.key = k; c.value = v; c.flags = f;
    return c;
  endfunction

  // Stimulus: directed corners, then random phases between clears.
  initial begin
    logic [31:0] pool[$];
    int unsigned n_ins, mode;
    logic [31:0] k;
    bit          big_done;
    big_done = 1'b0;
    map_clear();
    pending_cmds.push_back(mk_cmd(OP_LOOKUP, 32'd5, '0, '0));
    pending_cmds.push_back(mk_cmd(OP_LOOKUP, 32'd0, '0, '0));
    pending_cmds.push_back(mk_cmd(OP_INSERT, 32'd0, 32'hFFFF_FFFF, 8'hFF));
    pending_cmds.push_back(mk_cmd(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
    pending_cmds.push_back(mk_cmd(OP_INSERT, 32'd1, 32'd0, 8'h00));
    pending_cmds.push_back(mk_cmd(OP_INSERT, 32'd12, 32'hA5A5_5A5A, 8'h5A));
    pending_cmds.push_back(mk_cmd(OP_INSERT, 32'd1, 32'd77, 8'h01)); // duplicate
    pending_cmds.push_back(mk_cmd(OP_LOOKUP, 32'd12, '0, '0));
    pending_cmds.push_back(mk_cmd(OP_LOOKUP, 32'hFFFF_FFFF, '0, '0));
    pending_cmds.push_back(mk_cmd(OP_LOOKUP, 32'd1, '0, '0));
    pending_cmds.push_back(mk_cmd(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
    for (int i = 0; i < 8; i++)   // same home slot, forces growth and rehash
      pending_cmds.push_back(mk_cmd(OP_INSERT, 32'd11*(i+3), i, i[7:0]));
    pending_cmds.push_back(mk_cmd(OP_LOOKUP, 32'd33, '0, '0));
    pending_cmds.push_back(mk_cmd(OP_CLEAR, 32'd9, 32'd9, 8'd9));
    pending_cmds.push_back(mk_cmd(OP_LOOKUP, 32'd12, '0, '0));
    // Random phases; the first phase inserts enough keys to reach a full table.
    while (pending_cmds.size() < 2000) begin
      pool.delete();
      mode = big_done ? $urandom_range(1, 9) : 0;
      big_done = 1'b1;
      n_ins = (mode == 0) ? 1040 : $urandom_range(5, 60);
      for (int i = 0; i < n_ins + n_ins/2; i++) begin
        case ($urandom_range(0, 19))
          0: pending_cmds.push_back(mk_cmd(OP_INSERT, 32'd0, $urandom, $urandom));
          1: pending_cmds.push_back(mk_cmd(OP_NOP, $urandom, $urandom, $urandom));
          2, 3, 4, 5, 6: begin
            if (pool.size() > 0 && $urandom_range(0, 3) != 0)
              k = pool[$urandom_range(0, pool.size()-1)];
            else k = ($urandom_range(0, 1)) ? $urandom : $urandom_range(1, 64);
            pending_cmds.push_back(mk_cmd(OP_LOOKUP, k, $urandom, $urandom));
          end
          default: begin
            k = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 300) : $urandom;
            if (k == 0) k = 1;
            pool.push_back(k);
            pending_cmds.push_back(mk_cmd(OP_INSERT, k, $urandom, $urandom));
          end
        endcase
      end
      pending_cmds.push_back(mk_cmd(OP_CLEAR, $urandom, $urandom, $urandom));
    end
  end

  // Accept/ready decisions are made from values sampled at the rising edge.
  bit s_fire, m_fire;
  result_t got;

  // Driver: offers beats at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_fire) begin
        expected_results.push_back(map_apply(mk_cmd(s_user, s_data[31:0],
                                   s_data[63:32], s_data[71:64])));
        void'(pending_cmds.pop_front());
      end
      if (s_fire || !s_valid) begin
        if (pending_cmds.size() > 0 && (no_idle || $urandom_range(0, 99) >= 21)) begin
          s_valid <= 1'b1;
          s_user  <= pending_cmds[0].op;
          s_data  <= {pending_cmds[0].flags, pending_cmds[0].value,
                      pending_cmds[0].key};
        end else begin
          s_valid <= 1'b0;
          if (pending_cmds.size() == 0) stim_done = 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    s_fire <= s_valid && s_ready;
    m_fire = m_valid && m_ready;
    got = {m_user, m_data[31:0], m_data[39:32], m_data[41:40], m_data[51:42]};
    if (m_fire) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, got);
        mismatches++;
      end else if (got != expected_results[0]) begin
        $display("%0t: result mismatch expected %h actual %h",
                 $realtime, expected_results[0], got);
        mismatches++;
      end
      if (expected_results.size() > 0) void'(expected_results.pop_front());
    end
  end

  // Receiver: ready changes at the falling edge; idle and hold-off windows.
  always @(negedge clk_i) begin
    cyc <= cyc + 1;
    no_idle <= (cyc % 20000) < 3000;
    if (cyc == 5000) hold_off <= 400;
    else if (hold_off != 0) hold_off <= hold_off - 1;
    if (!rst_ni || hold_off > 1) m_ready <= 1'b0;
    else m_ready <= no_idle || $urandom_range(0, 99) >= 21;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    while (!(stim_done && expected_results.size() == 0 && !s_valid)) begin
      @(posedge clk_i);
      if (cyc > CYC_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
